// ===== sv/rltd_pkg.sv =====
// Package: parse phases, command bit positions and field widths for the token decoder.
`default_nettype none

package rltd_pkg;

    // Field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 15;
    localparam int unsigned HIGH_W = 6;

    // Command byte layout
    localparam int unsigned CMD_REPEAT_BIT = 7;
    localparam int unsigned CMD_WIDE_BIT   = 6;
    localparam logic [HIGH_W-1:0] CMD_COUNT_MASK = 6'h3F;

    // Length of a literal token
    localparam logic [LEN_W-1:0] LITERAL_LEN = 15'd1;

    // Parser phase
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_EXT     = 2'd1,
        PH_VALUE   = 2'd2,
        PH_LITERAL = 2'd3
    } phase_t;

    // Decoded token
    typedef struct packed {
        logic [BYTE_W-1:0] run_value;
        logic [LEN_W-1:0]  run_length;
        logic              from_repeat;
        logic              last_of_block;
        logic              truncated;
    } token_t;

endpackage : rltd_pkg

`default_nettype wire

// ===== sv/rltd_if.sv =====
// Interfaces: compressed byte channel and decoded token channel.
`default_nettype none

interface rltd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       block_end;

    modport source (output valid, output code_byte, output block_end, input ready);
    modport sink   (input valid, input code_byte, input block_end, output ready);
endinterface : rltd_in_if

interface rltd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  run_value;
    logic [14:0] run_length;
    logic        from_repeat;
    logic        last_of_block;
    logic        truncated;

    modport source (output valid, output run_value, output run_length, output from_repeat,
                    output last_of_block, output truncated, input ready);
    modport sink   (input valid, input run_value, input run_length, input from_repeat,
                    input last_of_block, input truncated, output ready);
endinterface : rltd_out_if

`default_nettype wire

// ===== sv/run_length_token_decoder_top.sv =====
// Top level: run-length command parser with input register and output token register.
//
//   channel    dir   handshake     payload
//   code_in    in    valid/ready   code_byte[7:0], block_end
//   token_out  out   valid/ready   run_value[7:0], run_length[14:0], from_repeat,
//                                  last_of_block, truncated
//
// One byte per cycle unless a token waits on the stalled token register; a byte
// goes through stage 1 and then the token register. Stage 1 holds the byte; the
// parser state and decode logic sit between it and the token register. Bytes that
// finish no token retire from stage 1 even while the token register is stalled.
// rst_n clears the parser to the header phase and empties both stages.
`default_nettype none

module run_length_token_decoder_top
    import rltd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    rltd_in_if.sink          code_in,
    rltd_out_if.source       token_out
);

    // Stage 1: input register
    logic              s1_valid_reg;
    logic [BYTE_W-1:0] code_reg;
    logic              end_reg;

    // Parser state
    phase_t            phase_reg, phase_next;
    logic              kind_reg, kind_next;
    logic [HIGH_W-1:0] high_reg, high_next;
    logic [LEN_W-1:0]  remain_reg, remain_next;

    // Token register
    logic              out_valid_reg;
    token_t            token_reg;

    // Decode results
    logic              have_token;
    logic              emit;
    token_t            token_next;
    logic [LEN_W-1:0]  hdr_len;
    logic [LEN_W-1:0]  ext_len;
    logic [LEN_W-1:0]  remain_dec;

    // Flow control
    logic              out_free;
    logic              s1_fire;
    logic              in_fire;

    assign out_free = !out_valid_reg || token_out.ready;
    assign s1_fire  = s1_valid_reg && (!emit || out_free);
    assign in_fire  = code_in.valid && code_in.ready;

    assign code_in.ready = !s1_valid_reg || s1_fire;

    // Count lengths: stored count plus one
    assign hdr_len    = {{(LEN_W-HIGH_W){1'b0}}, code_reg[HIGH_W-1:0] & CMD_COUNT_MASK}
                        + LEN_W'(1);
    assign ext_len    = {1'b0, high_reg, code_reg} + LEN_W'(1);
    assign remain_dec = (remain_reg != '0) ? remain_reg - LEN_W'(1) : remain_reg;

    // Next parser state
    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        high_next   = high_reg;
        remain_next = remain_reg;
        unique case (phase_reg)
            PH_HEADER:
            begin
                kind_next = code_reg[CMD_REPEAT_BIT];
                if (code_reg[CMD_WIDE_BIT])
                begin
                    high_next  = code_reg[HIGH_W-1:0] & CMD_COUNT_MASK;
                    phase_next = PH_EXT;
                end
                else
                begin
                    remain_next = hdr_len;
                    phase_next  = code_reg[CMD_REPEAT_BIT] ? PH_VALUE : PH_LITERAL;
                end
            end
            PH_EXT:
            begin
                remain_next = ext_len;
                phase_next  = kind_reg ? PH_VALUE : PH_LITERAL;
            end
            PH_VALUE:
            begin
                phase_next = PH_HEADER;
            end
            PH_LITERAL:
            begin
                remain_next = remain_dec;
                if (remain_dec == '0)
                    phase_next = PH_HEADER;
            end
            default:
            begin
                phase_next = PH_HEADER;
            end
        endcase
    end

    // Token fields
    always_comb
    begin
        have_token               = (phase_reg == PH_VALUE) || (phase_reg == PH_LITERAL);
        emit                     = have_token || end_reg;
        token_next.run_value     = have_token ? code_reg : '0;
        token_next.run_length    = '0;
        token_next.from_repeat   = 1'b0;
        if (phase_reg == PH_VALUE)
        begin
            token_next.run_length  = remain_reg;
            token_next.from_repeat = 1'b1;
        end
        else if (phase_reg == PH_LITERAL)
        begin
            token_next.run_length  = LITERAL_LEN;
        end
        token_next.last_of_block = end_reg;
        token_next.truncated     = end_reg && (phase_next != PH_HEADER);
    end

    // Stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            code_reg <= code_in.code_byte;
            end_reg  <= code_in.block_end;
        end
    end

    // Parser state; a block end returns everything to the header phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            kind_reg   <= 1'b0;
            high_reg   <= '0;
            remain_reg <= '0;
        end
        else if (s1_fire)
        begin
            if (end_reg)
            begin
                phase_reg  <= PH_HEADER;
                kind_reg   <= 1'b0;
                high_reg   <= '0;
                remain_reg <= '0;
            end
            else
            begin
                phase_reg  <= phase_next;
                kind_reg   <= kind_next;
                high_reg   <= high_next;
                remain_reg <= remain_next;
            end
        end
    end

    // Token register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire && emit)
            out_valid_reg <= 1'b1;
        else if (token_out.ready)
            out_valid_reg <= 1'b0;
    end

    // Token register payload
    always_ff @(posedge clk)
    begin
        if (s1_fire && emit)
            token_reg <= token_next;
    end

    assign token_out.valid         = out_valid_reg;
    assign token_out.run_value     = token_reg.run_value;
    assign token_out.run_length    = token_reg.run_length;
    assign token_out.from_repeat   = token_reg.from_repeat;
    assign token_out.last_of_block = token_reg.last_of_block;
    assign token_out.truncated     = token_reg.truncated;

endmodule : run_length_token_decoder_top

`default_nettype wire

// ===== sv/rltd_checker.sv =====
// Checker: port-level properties of the token decoder, bound to the top level.
`default_nettype none

module rltd_checker
    import rltd_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [BYTE_W-1:0] run_value,
    input wire logic [LEN_W-1:0]  run_length,
    input wire logic              from_repeat,
    input wire logic              last_of_block,
    input wire logic              truncated
);

    // A stalled item keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(run_value)
        && $stable(run_length) && $stable(from_repeat)
        && $stable(last_of_block) && $stable(truncated))
        else $error("token changed while stalled");

    // Truncation only on the last item of a block
    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && truncated |-> last_of_block)
        else $error("truncated without last_of_block");

    // A zero-length item is the end marker and carries nothing else
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_length == '0 |-> truncated && last_of_block
        && !from_repeat && run_value == '0)
        else $error("malformed end marker");

    // Literals have length one; repeats stay within the 14-bit count range
    a_lengths: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (from_repeat && run_length != '0 && run_length <= LEN_W'(16384))
        || (!from_repeat && (run_length == LITERAL_LEN || run_length == '0)))
        else $error("run_length out of range");

endmodule : rltd_checker

bind run_length_token_decoder_top rltd_checker u_rltd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (token_out.valid),
    .out_ready     (token_out.ready),
    .run_value     (token_out.run_value),
    .run_length    (token_out.run_length),
    .from_repeat   (token_out.from_repeat),
    .last_of_block (token_out.last_of_block),
    .truncated     (token_out.truncated)
);

`default_nettype wire

// ===== dv/run_length_token_decoder_top_tb.sv =====
// Testbench for the run-length token decoder: random byte streams checked against a token model.
`timescale 1ns / 100ps

import rltd_pkg::*;

// Token model and in-order result checker
class token_scoreboard;
    token_t            pending_q[$];
    phase_t            phase;
    bit                rep_kind;
    logic [HIGH_W-1:0] high_bits;
    logic [LEN_W-1:0]  remaining;
    int unsigned       mismatches;
    int unsigned       reported;

    function new();
        clear_parser();
        mismatches = 0;
        reported   = 0;
    endfunction

    function void clear_parser();
        phase     = PH_HEADER;
        rep_kind  = 1'b0;
        high_bits = '0;
        remaining = '0;
    endfunction

    function int unsigned pending_count();
        return pending_q.size();
    endfunction

    function string fmt(token_t t);
        return $sformatf("value=%02h len=%0d rep=%0b last=%0b trunc=%0b",
                         t.run_value, t.run_length, t.from_repeat,
                         t.last_of_block, t.truncated);
    endfunction

    // Advance the parser by one accepted byte; queue the token it yields, if any
    function void note_input(logic [BYTE_W-1:0] b, logic block_end);
        bit     have;
        token_t tok;
        have = 1'b0;
        tok  = '0;
        case (phase)
            PH_HEADER:
            begin
                rep_kind = b[CMD_REPEAT_BIT];
                if (b[CMD_WIDE_BIT])
                begin
                    high_bits = b[HIGH_W-1:0];
                    phase     = PH_EXT;
                end
                else
                begin
                    remaining = {{(LEN_W-HIGH_W){1'b0}}, b[HIGH_W-1:0]} + 1'b1;
                    phase     = rep_kind ? PH_VALUE : PH_LITERAL;
                end
            end
            PH_EXT:
            begin
                remaining = {1'b0, high_bits, b} + 1'b1;
                phase     = rep_kind ? PH_VALUE : PH_LITERAL;
            end
            PH_VALUE:
            begin
                have            = 1'b1;
                tok.run_value   = b;
                tok.run_length  = remaining;
                tok.from_repeat = 1'b1;
                phase           = PH_HEADER;
            end
            default:
            begin
                have            = 1'b1;
                tok.run_value   = b;
                tok.run_length  = LITERAL_LEN;
                tok.from_repeat = 1'b0;
                if (remaining != 0)
                    remaining = remaining - 1'b1;
                if (remaining == 0)
                    phase = PH_HEADER;
            end
        endcase

        if (block_end)
        begin
            // block end always yields a token; a bare marker when nothing was decoded
            tok.last_of_block = 1'b1;
            tok.truncated     = (phase != PH_HEADER);
            pending_q.push_back(tok);
            clear_parser();
        end
        else if (have)
            pending_q.push_back(tok);
    endfunction

    // Compare one delivered token against the oldest expected one
    function void check_token(token_t got);
        token_t want;
        if (pending_q.size() == 0)
        begin
            mismatches++;
            if (reported < 10)
            begin
                reported++;
                $display("ERROR: unexpected token: %s", fmt(got));
            end
            return;
        end
        want = pending_q.pop_front();
        if (got.run_value !== want.run_value || got.run_length !== want.run_length ||
            got.from_repeat !== want.from_repeat ||
            got.last_of_block !== want.last_of_block || got.truncated !== want.truncated)
        begin
            mismatches++;
            if (reported < 10)
            begin
                reported++;
                $display("ERROR: token mismatch at %0t", $time);
                $display("  expected %s", fmt(want));
                $display("  actual   %s", fmt(got));
            end
        end
    endfunction
endclass

module run_length_token_decoder_top_tb;

    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_AT      = 400;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } code_item_t;

    logic clk;
    logic rst_n;

    rltd_in_if  code_in_bus ();
    rltd_out_if token_bus ();

    run_length_token_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .code_in   (code_in_bus),
        .token_out (token_bus)
    );

    token_scoreboard sb = new();
    code_item_t      stim_q[$];
    int unsigned     bytes_taken;
    int unsigned     idle_cycles;
    bit              no_idle;
    bit              held_off;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void push_byte(logic [7:0] b, logic last);
        code_item_t it;
        it.code = b;
        it.last = last;
        stim_q.push_back(it);
    endfunction

    // One command, mostly well formed; occasionally cut short by a block end
    function automatic void gen_command(bit close_block);
        bit              rep;
        bit              wide;
        bit              cut_early;
        logic [5:0]      hi;
        logic [7:0]      lo;
        logic [7:0]      hdr;
        int unsigned     len;
        int unsigned     body;
        rep       = 1'($urandom_range(0, 1));
        wide      = ($urandom_range(0, 3) == 0);
        cut_early = ($urandom_range(0, 24) == 0);
        if (wide)
        begin
            hi = 6'($urandom_range(0, 63));
            lo = 8'($urandom_range(0, 255));
            if (!rep && $urandom_range(0, 1))
            begin
                hi = '0;
                lo = 8'($urandom_range(0, 15));
            end
            hdr = {rep, 1'b1, hi};
            if (cut_early && $urandom_range(0, 1))
            begin
                push_byte(hdr, 1'b1);
                return;
            end
            push_byte(hdr, 1'b0);
            if (cut_early)
            begin
                push_byte(lo, 1'b1);
                return;
            end
            push_byte(lo, 1'b0);
            len = {hi, lo} + 1;
        end
        else
        begin
            if (rep || $urandom_range(0, 3) == 0)
                hi = 6'($urandom_range(0, 63));
            else
                hi = 6'($urandom_range(0, 7));
            hdr = {rep, 1'b0, hi};
            if (cut_early)
            begin
                push_byte(hdr, 1'b1);
                return;
            end
            push_byte(hdr, 1'b0);
            len = hi + 1;
        end

        if (rep)
            push_byte(8'($urandom_range(0, 255)), close_block);
        else
        begin
            // long literal runs are ended early by a block end
            body = len;
            if (body > 70)
                body = $urandom_range(1, 12);
            for (int unsigned i = 0; i < body; i++)
                push_byte(8'($urandom_range(0, 255)),
                          (i == body - 1) && (close_block || body < len));
        end
    endfunction

    function automatic void gen_random(int unsigned count);
        int unsigned start;
        start = stim_q.size();
        while (stim_q.size() - start < count)
        begin
            if ($urandom_range(0, 99) < 5)
                push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            else
                gen_command($urandom_range(0, 7) == 0);
        end
    endfunction

    // Offer one byte, with an occasional idle burst in front; called at a falling edge
    task automatic send_item(code_item_t it);
        int unsigned gap;
        if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 8);
            code_in_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        code_in_bus.valid     <= 1'b1;
        code_in_bus.code_byte <= it.code;
        code_in_bus.block_end <= it.last;
        do
            @(posedge clk);
        while (!code_in_bus.ready);
        @(negedge clk);
    endtask

    task automatic send_queued();
        while (stim_q.size() != 0)
            send_item(stim_q.pop_front());
    endtask

    // Stop offering and wait until every expected token has come out
    task automatic wait_drained();
        code_in_bus.valid <= 1'b0;
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Sender and run control
    initial
    begin
        code_in_bus.valid     = 1'b0;
        code_in_bus.code_byte = '0;
        code_in_bus.block_end = 1'b0;
        no_idle               = 1'b0;
        rst_n                 = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: length extremes, both command kinds, every block-end case
        push_byte(8'h80, 1'b0); push_byte(8'h00, 1'b0);                        // repeat x1
        push_byte(8'hBF, 1'b0); push_byte(8'hFF, 1'b0);                        // repeat x64
        push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hAA, 1'b0); // repeat x16384
        push_byte(8'hC0, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h55, 1'b1); // ends on value
        push_byte(8'h00, 1'b0); push_byte(8'h7F, 1'b0);                        // one literal
        push_byte(8'h40, 1'b0); push_byte(8'h01, 1'b0);                        // wide literal x2
        push_byte(8'h12, 1'b0); push_byte(8'h34, 1'b0);
        push_byte(8'h02, 1'b0); push_byte(8'hFE, 1'b0); push_byte(8'h01, 1'b1); // cut in literal
        push_byte(8'h85, 1'b1);                                                // ends on header
        push_byte(8'hC3, 1'b0); push_byte(8'h10, 1'b1);                        // ends on extension
        push_byte(8'h01, 1'b0); push_byte(8'h11, 1'b0); push_byte(8'h22, 1'b1); // literal, clean end
        send_queued();

        // Random with idling; the receiver's long hold-off lands in here
        gen_random(800);
        send_queued();

        // Sender pauses until every token is out
        wait_drained();
        gen_random(600);
        send_queued();

        // Final stretch with no idling on either side
        no_idle = 1'b1;
        gen_random(250);
        send_queued();

        wait_drained();
        if (sb.mismatches == 0 && sb.pending_count() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Receiver: random stall bursts and one long hold-off
    initial
    begin
        int unsigned gap;
        token_bus.ready = 1'b0;
        held_off        = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && bytes_taken >= HOLD_AT)
            begin
                held_off = 1'b1;
                token_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                gap = $urandom_range(1, 8);
                token_bus.ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                token_bus.ready <= 1'b1;
        end
    end

    // Monitor: check tokens, note accepted bytes, watch for a stuck run
    initial
    begin
        token_t got;
        bytes_taken = 0;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (token_bus.valid && token_bus.ready)
                begin
                    got.run_value     = token_bus.run_value;
                    got.run_length    = token_bus.run_length;
                    got.from_repeat   = token_bus.from_repeat;
                    got.last_of_block = token_bus.last_of_block;
                    got.truncated     = token_bus.truncated;
                    sb.check_token(got);
                end
                if (code_in_bus.valid && code_in_bus.ready)
                begin
                    sb.note_input(code_in_bus.code_byte, code_in_bus.block_end);
                    bytes_taken++;
                end
                if ((token_bus.valid && token_bus.ready) ||
                    (code_in_bus.valid && code_in_bus.ready))
                    idle_cycles = 0;
                else
                    idle_cycles++;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

endmodule
